// File: sv/obb_pkg.sv
// Shared types and constants of the 2D oriented box overlap tester.
`default_nettype none
package obb_pkg;

	localparam int COORD_WIDTH_DEF    = 24;
	localparam int AXIS_FRAC_BITS_DEF = 14;
	localparam int AXIS_COUNT         = 4;
	localparam int AXIS_IDX_W         = 2;

	typedef enum logic [AXIS_IDX_W-1:0] {
		AX_REF_U,
		AX_REF_V,
		AX_TST_U,
		AX_TST_V
	} axis_sel_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_HOLD
	} ctrl_state_t;

	typedef struct packed {
		logic      load_ref;
		logic      load_tst;
		logic      issue;
		axis_sel_t axis;
		logic      last;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
	} dp_status_t;

endpackage
`default_nettype wire

// File: sv/obb_dpath.sv
// Datapath: reference and test box registers, shared projection pipeline and result flag.
`default_nettype none
module obb_dpath
	import obb_pkg::*;
#(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire dp_cmd_t                             cmd,
	output dp_status_t                               status,
	input  wire logic signed [COORD_WIDTH-1:0]       center_x,
	input  wire logic signed [COORD_WIDTH-1:0]       center_y,
	input  wire logic signed [AXIS_FRAC_BITS+1:0]    axis_u_x,
	input  wire logic signed [AXIS_FRAC_BITS+1:0]    axis_u_y,
	input  wire logic signed [AXIS_FRAC_BITS+1:0]    axis_v_x,
	input  wire logic signed [AXIS_FRAC_BITS+1:0]    axis_v_y,
	input  wire logic        [COORD_WIDTH-2:0]       half_len_u,
	input  wire logic        [COORD_WIDTH-2:0]       half_len_v,
	output logic                                     overlap
);

	localparam int CW    = COORD_WIDTH;
	localparam int AF    = AXIS_FRAC_BITS;
	localparam int AW    = AF + 2;
	localparam int HW    = CW - 1;
	localparam int DW    = CW + 1;
	localparam int PCW   = DW + AW;
	localparam int SCW   = PCW + 1;
	localparam int CDW   = SCW - 1;
	localparam int PW    = 2 * AW;
	localparam int SPW   = PW + 1;
	localparam int HPW   = PW + HW;
	localparam int LW    = CDW + AF;
	localparam int CMP_W = CW + 2 * AW + 1;

	logic signed [CW-1:0] ref_cx_q, ref_cy_q;
	logic signed [AW-1:0] ref_ux_q, ref_uy_q, ref_vx_q, ref_vy_q;
	logic        [HW-1:0] ref_lu_q, ref_lv_q;

	logic signed [AW-1:0] tst_ux_q, tst_uy_q, tst_vx_q, tst_vy_q;
	logic        [HW-1:0] tst_lu_q, tst_lv_q;
	logic signed [DW-1:0] d_x_q, d_y_q;

	logic signed [AW-1:0] ax, ay, px, py, qx, qy;
	logic        [HW-1:0] own, pl, ql;

	logic                  valid_s1, last_s1;
	logic signed [PCW-1:0] pcd_x_s1, pcd_y_s1;
	logic signed [PW-1:0]  pp_x_s1, pp_y_s1, pq_x_s1, pq_y_s1;
	logic        [HW-1:0]  own_s1, pl_s1, ql_s1;

	logic signed [SCW-1:0] sum_cd, neg_cd;
	logic signed [SPW-1:0] sum_p, neg_p, sum_q, neg_q;

	logic                  valid_s2, last_s2;
	logic        [CDW-1:0] cd_s2;
	logic        [PW-1:0]  dp_s2, dq_s2;
	logic        [HW-1:0]  own_s2, pl_s2, ql_s2;

	logic                  valid_s3, last_s3;
	logic        [LW-1:0]  lhs_s3;
	logic        [HPW-1:0] prod_p_s3, prod_q_s3;
	logic        [HW-1:0]  own_s3;

	logic [CMP_W-1:0] rhs;
	logic             sep;
	logic             acc_q, done_q, overlap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_cx_q <= '0;
			ref_cy_q <= '0;
			ref_ux_q <= '0;
			ref_uy_q <= '0;
			ref_vx_q <= '0;
			ref_vy_q <= '0;
			ref_lu_q <= '0;
			ref_lv_q <= '0;
		end else if (cmd.load_ref) begin
			ref_cx_q <= center_x;
			ref_cy_q <= center_y;
			ref_ux_q <= axis_u_x;
			ref_uy_q <= axis_u_y;
			ref_vx_q <= axis_v_x;
			ref_vy_q <= axis_v_y;
			ref_lu_q <= half_len_u;
			ref_lv_q <= half_len_v;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_tst) begin
			tst_ux_q <= axis_u_x;
			tst_uy_q <= axis_u_y;
			tst_vx_q <= axis_v_x;
			tst_vy_q <= axis_v_y;
			tst_lu_q <= half_len_u;
			tst_lv_q <= half_len_v;
			d_x_q    <= DW'(ref_cx_q) - DW'(center_x);
			d_y_q    <= DW'(ref_cy_q) - DW'(center_y);
		end
	end

	always_comb begin
		unique case (cmd.axis)
			AX_REF_U: begin
				ax = ref_ux_q; ay = ref_uy_q; own = ref_lu_q;
				px = tst_ux_q; py = tst_uy_q; pl = tst_lu_q;
				qx = tst_vx_q; qy = tst_vy_q; ql = tst_lv_q;
			end
			AX_REF_V: begin
				ax = ref_vx_q; ay = ref_vy_q; own = ref_lv_q;
				px = tst_ux_q; py = tst_uy_q; pl = tst_lu_q;
				qx = tst_vx_q; qy = tst_vy_q; ql = tst_lv_q;
			end
			AX_TST_U: begin
				ax = tst_ux_q; ay = tst_uy_q; own = tst_lu_q;
				px = ref_ux_q; py = ref_uy_q; pl = ref_lu_q;
				qx = ref_vx_q; qy = ref_vy_q; ql = ref_lv_q;
			end
			AX_TST_V: begin
				ax = tst_vx_q; ay = tst_vy_q; own = tst_lv_q;
				px = ref_ux_q; py = ref_uy_q; pl = ref_lu_q;
				qx = ref_vx_q; qy = ref_vy_q; ql = ref_lv_q;
			end
			default: begin
				ax = '0; ay = '0; own = '0;
				px = '0; py = '0; pl = '0;
				qx = '0; qy = '0; ql = '0;
			end
		endcase
	end

	always_comb begin
		sum_cd = SCW'(pcd_x_s1) + SCW'(pcd_y_s1);
		neg_cd = -sum_cd;
		sum_p  = SPW'(pp_x_s1) + SPW'(pp_y_s1);
		neg_p  = -sum_p;
		sum_q  = SPW'(pq_x_s1) + SPW'(pq_y_s1);
		neg_q  = -sum_q;
		rhs    = CMP_W'({own_s3, {(2 * AF){1'b0}}}) + CMP_W'(prod_p_s3)
			+ CMP_W'(prod_q_s3);
		sep    = CMP_W'(lhs_s3) > rhs;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			last_s2  <= 1'b0;
			valid_s3 <= 1'b0;
			last_s3  <= 1'b0;
			acc_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			last_s1  <= cmd.issue & cmd.last;
			valid_s2 <= valid_s1;
			last_s2  <= last_s1;
			valid_s3 <= valid_s2;
			last_s3  <= last_s2;
			done_q   <= valid_s3 & last_s3;
			if (cmd.load_tst) begin
				acc_q <= 1'b0;
			end else if (valid_s3) begin
				acc_q <= acc_q | sep;
			end
		end
	end

	always_ff @(posedge clk) begin
		pcd_x_s1  <= d_x_q * ax;
		pcd_y_s1  <= d_y_q * ay;
		pp_x_s1   <= px * ax;
		pp_y_s1   <= py * ay;
		pq_x_s1   <= qx * ax;
		pq_y_s1   <= qy * ay;
		own_s1    <= own;
		pl_s1     <= pl;
		ql_s1     <= ql;

		cd_s2     <= sum_cd[SCW-1] ? neg_cd[CDW-1:0] : sum_cd[CDW-1:0];
		dp_s2     <= sum_p[SPW-1] ? neg_p[PW-1:0] : sum_p[PW-1:0];
		dq_s2     <= sum_q[SPW-1] ? neg_q[PW-1:0] : sum_q[PW-1:0];
		own_s2    <= own_s1;
		pl_s2     <= pl_s1;
		ql_s2     <= ql_s1;

		lhs_s3    <= {cd_s2, {AF{1'b0}}};
		prod_p_s3 <= dp_s2 * pl_s2;
		prod_q_s3 <= dq_s2 * ql_s2;
		own_s3    <= own_s2;

		if (cmd.out_load) begin
			overlap_q <= ~acc_q;
		end
	end

	assign status.done = done_q;
	assign overlap     = overlap_q;

endmodule
`default_nettype wire

// File: sv/obb_ctrl.sv
// Controller: accepts transactions, steps the four candidate axes and owns the result valid.
`default_nettype none
module obb_ctrl
	import obb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       req_type,
	output logic            out_valid,
	input  wire logic       out_stall,
	output dp_cmd_t         cmd,
	input  wire dp_status_t status
);

	ctrl_state_t           state_q, state_d;
	logic [AXIS_IDX_W-1:0] cnt_q, cnt_d;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		in_stall     = 1'b1;
		cmd          = '0;
		cmd.axis     = axis_sel_t'(cnt_q);
		cmd.last     = cnt_q == AXIS_IDX_W'(AXIS_COUNT - 1);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (req_type) begin
						cmd.load_tst = 1'b1;
						cnt_d        = '0;
						state_d      = ST_ISSUE;
					end else begin
						cmd.load_ref = 1'b1;
					end
				end
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				cnt_d     = cnt_q + AXIS_IDX_W'(1);
				if (cmd.last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (status.done) begin
					if (out_free) begin
						cmd.out_load = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						state_d = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// File: sv/obb_overlap_test_2d.sv
// Top level of the 2D oriented box overlap tester.
// A load transaction keeps the controller idle, and the next one is accepted right after it.
// A test transaction steps the four axes, one axis entering the shared projection pipeline
// per cycle; the result is registered once the output is free, and the next transaction
// is accepted in the same cycle as that result appears with out_valid.
// Asynchronous reset clears the reference box to zero and empties the output.
`default_nettype none
module obb_overlap_test_2d
	import obb_pkg::*;
#(
	parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
	parameter int AXIS_FRAC_BITS = AXIS_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic                             req_type,
	input  wire logic signed [COORD_WIDTH-1:0]    center_x,
	input  wire logic signed [COORD_WIDTH-1:0]    center_y,
	input  wire logic signed [AXIS_FRAC_BITS+1:0] axis_u_x,
	input  wire logic signed [AXIS_FRAC_BITS+1:0] axis_u_y,
	input  wire logic signed [AXIS_FRAC_BITS+1:0] axis_v_x,
	input  wire logic signed [AXIS_FRAC_BITS+1:0] axis_v_y,
	input  wire logic        [COORD_WIDTH-2:0]    half_len_u,
	input  wire logic        [COORD_WIDTH-2:0]    half_len_v,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  overlap
);

	dp_cmd_t    cmd;
	dp_status_t status;

	obb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	obb_dpath #(
		.COORD_WIDTH    (COORD_WIDTH),
		.AXIS_FRAC_BITS (AXIS_FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.center_x   (center_x),
		.center_y   (center_y),
		.axis_u_x   (axis_u_x),
		.axis_u_y   (axis_u_y),
		.axis_v_x   (axis_v_x),
		.axis_v_y   (axis_v_y),
		.half_len_u (half_len_u),
		.half_len_v (half_len_v),
		.overlap    (overlap)
	);

endmodule
`default_nettype wire

// File: sv/obb_chk.sv
// Port-level checker of the overlap tester and its bind to the top level.
`default_nettype none
module obb_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic req_type,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic overlap
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(overlap))
		else $error("Stalled result transaction changed or vanished.");

	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && req_type |=> in_stall)
		else $error("Input not stalled while a test transaction is in work.");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !req_type |=> !in_stall)
		else $error("Load transaction blocked the input.");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("Result transaction appeared without a test in work.");

endmodule

bind obb_overlap_test_2d obb_chk u_obb_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.req_type  (req_type),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.overlap   (overlap)
);
`default_nettype wire
